// File: sv/sxf_pkg.sv
// Package for the sprite XOR framebuffer: geometry constants, request codes, state type.
package sxf_pkg;

    localparam int SCREEN_COLS = 64;
    localparam int SCREEN_ROWS = 32;
    localparam int FRAME_BYTES = (SCREEN_COLS * SCREEN_ROWS + 7) / 8;
    localparam int ADDR_W      = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam int POS_W       = $clog2(SCREEN_COLS) + 10;
    localparam int IDX_W       = POS_W - 3;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_DRAW  = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRAW0,
        S_DRAW1,
        S_READ,
        S_DONE
    } t_state;

endpackage

// File: sv/sxf_intf.sv
// Request and response channel interfaces for the sprite XOR framebuffer.
interface sxf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] start_x;
    logic [8:0] row_y;
    logic [7:0] sprite_bits;
    logic       first_row;
    logic [7:0] read_addr;

    modport source (
        output valid, req_type, start_x, row_y, sprite_bits, first_row, read_addr,
        input  ready
    );
    modport sink (
        input  valid, req_type, start_x, row_y, sprite_bits, first_row, read_addr,
        output ready
    );
endinterface

interface sxf_rsp_if;
    logic       valid;
    logic       ready;
    logic       collision_flag;
    logic [7:0] read_data;

    modport source (output valid, collision_flag, read_data, input ready);
    modport sink   (input valid, collision_flag, read_data, output ready);
endinterface

// File: sv/sprite_xor_framebuffer_top.sv
// Sprite XOR framebuffer: packed 1-bit store with clear, draw-row and byte-read requests.
// A draw steps through S_DRAW0 and S_DRAW1, two read-modify-write passes on the store;
// a read goes through S_READ, a clear through S_DONE. The result is registered; the last
// state holds while the response slot is full. A request is taken while a result waits.
// Reset (synchronous): clears control state, collision flag and per-byte valid bits,
// so the whole store reads as zero at once; a clear request clears only the valid bits.
module sprite_xor_framebuffer_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sxf_req_if.sink  i_req,
    sxf_rsp_if.source o_rsp
);
    import sxf_pkg::*;

    t_state r_state, n_state;

    logic [7:0]             r_mem [FRAME_BYTES];
    logic [FRAME_BYTES-1:0] r_valid;
    logic [7:0]             r_rdata;
    logic                   r_rd_valid;

    logic [ADDR_W-1:0] r_idx0, r_idx1;
    logic [15:0]       r_mask;
    logic              r_we0, r_we1, r_rd_ok;
    logic              r_hit, n_hit;

    logic       r_out_valid, r_out_hit;
    logic [7:0] r_out_data;

    logic              in_fire, out_free, out_load, out_hit;
    logic [7:0]        out_data;
    logic              mem_re, mem_we;
    logic [ADDR_W-1:0] mem_raddr, mem_waddr;
    logic [7:0]        mem_wdata, rd;

    logic [7:0]       clip_bits;
    logic             row_ok;
    logic [POS_W-1:0] pos0;
    logic [IDX_W-1:0] idx0, idx1;
    logic [15:0]      mask16;
    logic             addr_ok;

    assign in_fire     = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign rd          = r_rd_valid ? r_rdata : 8'h00;

    // request geometry
    assign row_ok = 9'(i_req.row_y) < 9'(SCREEN_ROWS);
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            clip_bits[7-i] = i_req.sprite_bits[7-i] && row_ok &&
                             ((9'(i_req.start_x) + 9'(i)) < 9'(SCREEN_COLS));
        end
    end
    assign pos0    = POS_W'(i_req.row_y) * POS_W'(SCREEN_COLS) + POS_W'(i_req.start_x);
    assign idx0    = pos0[POS_W-1:3];
    assign idx1    = IDX_W'(idx0 + 1'b1);
    assign mask16  = {clip_bits, 8'h00} >> pos0[2:0];
    assign addr_ok = 32'(i_req.read_addr) < 32'(FRAME_BYTES);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    priority case (t_req_kind'(i_req.req_type))
                        REQ_DRAW: n_state = S_DRAW0;
                        REQ_READ: n_state = S_READ;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_DRAW0: n_state = S_DRAW1;
            S_DRAW1, S_READ, S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and store control
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = r_idx1;
        mem_we    = 1'b0;
        mem_waddr = r_idx0;
        mem_wdata = rd ^ r_mask[15:8];
        n_hit     = r_hit;
        out_load  = 1'b0;
        out_hit   = r_hit;
        out_data  = 8'h00;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire && (i_req.req_type == REQ_DRAW)) begin
                    mem_re    = 1'b1;
                    mem_raddr = ADDR_W'(idx0);
                    if (i_req.first_row) n_hit = 1'b0;
                end else if (in_fire && (i_req.req_type == REQ_READ)) begin
                    mem_re    = 1'b1;
                    mem_raddr = ADDR_W'(i_req.read_addr);
                end
            end
            S_DRAW0: begin
                mem_we = r_we0;
                mem_re = 1'b1;
                n_hit  = r_hit | (r_we0 && |(rd & r_mask[15:8]));
            end
            S_DRAW1: begin
                mem_waddr = r_idx1;
                mem_wdata = rd ^ r_mask[7:0];
                if (out_free) begin
                    mem_we   = r_we1;
                    n_hit    = r_hit | (r_we1 && |(rd & r_mask[7:0]));
                    out_load = 1'b1;
                    out_hit  = n_hit;
                end
            end
            S_READ: begin
                out_load = out_free;
                out_data = r_rd_ok ? rd : 8'h00;
            end
            S_DONE: out_load = out_free;
            default: ;
        endcase
    end

    // frame store
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (mem_re) r_rd_valid <= r_valid[mem_raddr];
            if (in_fire && (i_req.req_type == REQ_CLEAR)) begin
                r_valid <= '0;
            end else if (mem_we) begin
                r_valid[mem_waddr] <= 1'b1;
            end
        end
    end

    // request registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_idx0  <= ADDR_W'(idx0);
            r_idx1  <= ADDR_W'(idx1);
            r_mask  <= mask16;
            r_we0   <= (|mask16[15:8]) && (32'(idx0) < 32'(FRAME_BYTES));
            r_we1   <= (|mask16[7:0]) && (32'(idx1) < 32'(FRAME_BYTES));
            r_rd_ok <= addr_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hit   <= n_hit;
            if (out_load)         r_out_valid <= 1'b1;
            else if (o_rsp.ready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_hit  <= out_hit;
            r_out_data <= out_data;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.collision_flag = r_out_hit;
    assign o_rsp.read_data      = r_out_data;

    a_write_in_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_DRAW0 || r_state == S_DRAW1))
        else $error("store write outside a draw");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write hit the same byte");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_req.req_type == REQ_CLEAR)) |=> (r_valid == '0))
        else $error("clear left valid bytes");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || o_rsp.ready))
        else $error("result overwrote a pending transfer");

endmodule

// File: bench/sxf_frame_checker.sv
// Framebuffer checker: mirrors the pixel store, predicts each response and compares it.
module sxf_frame_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    sxf_req_if   i_req,
    sxf_rsp_if   i_rsp,
    output int   o_err_count,
    output int   o_pending,
    output int   o_checked
);
    import sxf_pkg::*;

    typedef struct packed {
        logic       collision;
        logic [7:0] data;
    } t_rsp_exp;

    logic [7:0] fb_bytes [FRAME_BYTES];
    logic       collide_latch;
    t_rsp_exp   rsp_expected [$];

    // XOR one sprite row into the mirror, clipping at the right and bottom edges
    function automatic void xor_sprite_row(logic [7:0] x0, logic [8:0] y, logic [7:0] bits);
        int col;
        int pos;
        int idx;
        int bitpos;
        if (int'(y) >= SCREEN_ROWS) begin
            return;
        end
        for (int i = 0; i < 8; i++) begin
            col = int'(x0) + i;
            if (col >= SCREEN_COLS) begin
                break;
            end
            if (!bits[7 - i]) begin
                continue;
            end
            pos    = int'(y) * SCREEN_COLS + col;
            idx    = pos / 8;
            if (idx >= FRAME_BYTES) begin
                continue;
            end
            bitpos = 7 - (pos % 8);
            if (fb_bytes[idx][bitpos]) begin
                collide_latch = 1'b1;
            end
            fb_bytes[idx][bitpos] = ~fb_bytes[idx][bitpos];
        end
    endfunction

    function automatic t_rsp_exp predict_response(t_req_kind kind, logic [7:0] x0,
                                                  logic [8:0] y, logic [7:0] bits,
                                                  logic first, logic [7:0] addr);
        t_rsp_exp r;
        r.data = 8'h00;
        case (kind)
            REQ_CLEAR: begin
                for (int i = 0; i < FRAME_BYTES; i++) begin
                    fb_bytes[i] = 8'h00;
                end
            end
            REQ_DRAW: begin
                if (first) begin
                    collide_latch = 1'b0;
                end
                xor_sprite_row(x0, y, bits);
            end
            REQ_READ: begin
                if (int'(addr) < FRAME_BYTES) begin
                    r.data = fb_bytes[addr];
                end
            end
            default: ;
        endcase
        r.collision = collide_latch;
        return r;
    endfunction

    initial begin
        o_err_count = 0;
        o_pending   = 0;
        o_checked   = 0;
    end

    always @(posedge i_clk) begin
        t_rsp_exp exp_rsp;
        int       n_err;
        if (!i_rst_n) begin
            for (int i = 0; i < FRAME_BYTES; i++) begin
                fb_bytes[i] = 8'h00;
            end
            collide_latch = 1'b0;
            rsp_expected.delete();
            o_pending <= 0;
        end else begin
            n_err = 0;
            // response first: a request transferred on this edge cannot be answered yet
            if (i_rsp.valid && i_rsp.ready) begin
                if (rsp_expected.size() == 0) begin
                    $display("%0t: response transfer with nothing outstanding (flag %0b data %h)",
                             $time, i_rsp.collision_flag, i_rsp.read_data);
                    n_err++;
                end else begin
                    exp_rsp = rsp_expected.pop_front();
                    o_checked <= o_checked + 1;
                    if (i_rsp.collision_flag !== exp_rsp.collision) begin
                        $display("%0t: collision_flag expected %0b actual %0b",
                                 $time, exp_rsp.collision, i_rsp.collision_flag);
                        n_err++;
                    end
                    if (i_rsp.read_data !== exp_rsp.data) begin
                        $display("%0t: read_data expected %h actual %h",
                                 $time, exp_rsp.data, i_rsp.read_data);
                        n_err++;
                    end
                end
            end
            if (n_err != 0) begin
                o_err_count <= o_err_count + n_err;
            end
            if (i_req.valid && i_req.ready) begin
                rsp_expected.push_back(predict_response(t_req_kind'(i_req.req_type),
                                                        i_req.start_x, i_req.row_y,
                                                        i_req.sprite_bits, i_req.first_row,
                                                        i_req.read_addr));
            end
            o_pending <= rsp_expected.size();
        end
    end

endmodule

// File: bench/testbench.sv
// Testbench top: clock, reset, request stimulus, response back-pressure and verdict.
module testbench;
    import sxf_pkg::*;

    localparam int RUN_LIMIT    = 200000;
    localparam int RANDOM_ITEMS = 900;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sxf_req_if req_ch ();
    sxf_rsp_if rsp_ch ();

    int err_count;
    int pending;
    int checked;
    int cycle_count;
    int n_draw;
    int n_read;
    int n_clear;
    int n_spare;
    int n_sent;
    bit send_no_gaps;

    sprite_xor_framebuffer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    sxf_frame_checker u_frame_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .i_rsp       (rsp_ch),
        .o_err_count (err_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic send_request(t_req_kind kind, logic [7:0] x0, logic [8:0] y,
                                logic [7:0] bits, logic first, logic [7:0] addr);
        int gap;
        gap = send_no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.start_x     <= x0;
        req_ch.row_y       <= y;
        req_ch.sprite_bits <= bits;
        req_ch.first_row   <= first;
        req_ch.read_addr   <= addr;
        do @(posedge i_clk); while (!req_ch.ready);
        n_sent++;
        case (kind)
            REQ_DRAW:  n_draw++;
            REQ_READ:  n_read++;
            REQ_CLEAR: n_clear++;
            default:   n_spare++;
        endcase
    endtask

    task automatic send_sprite();
        int         rows;
        logic [7:0] x0;
        logic [8:0] y0;
        rows = $urandom_range(1, 15);
        x0   = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 70));
        y0   = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                           : 9'($urandom_range(0, 40));
        for (int r = 0; r < rows; r++) begin
            send_request(REQ_DRAW, x0, y0 + 9'(r), 8'($urandom),
                         (r == 0) ? 1'b1 : ($urandom_range(0, 19) == 0),
                         8'($urandom));
        end
    endtask

    // response side: random stall per result, with stall-free stretches
    initial begin
        int stall;
        int n_rsp;
        bit rsp_no_stall;
        n_rsp        = 0;
        rsp_no_stall = 1'b0;
        rsp_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (n_rsp % 32 == 0) begin
                rsp_no_stall = ($urandom_range(0, 2) == 0);
            end
            stall = rsp_no_stall ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            n_rsp++;
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int pick;
        int n;
        n_draw  = 0;
        n_read  = 0;
        n_clear = 0;
        n_spare = 0;
        n_sent  = 0;
        send_no_gaps = 1'b0;

        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= REQ_CLEAR;
        req_ch.start_x     <= 8'h00;
        req_ch.row_y       <= 9'h000;
        req_ch.sprite_bits <= 8'h00;
        req_ch.first_row   <= 1'b0;
        req_ch.read_addr   <= 8'h00;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset contents, collision, clipping, straddle, ignored fields
        send_request(REQ_READ,  8'h00, 9'd0,   8'h00, 1'b1, 8'h00);
        send_request(REQ_DRAW,  8'd0,  9'd0,   8'hFF, 1'b1, 8'h00);
        send_request(REQ_DRAW,  8'd0,  9'd0,   8'hFF, 1'b0, 8'h00);
        send_request(REQ_READ,  8'h00, 9'd0,   8'h00, 1'b0, 8'h00);
        send_request(REQ_DRAW,  8'd60, 9'd0,   8'hFF, 1'b1, 8'h00);
        send_request(REQ_READ,  8'h00, 9'd0,   8'h00, 1'b0, 8'd7);
        send_request(REQ_READ,  8'h00, 9'd0,   8'h00, 1'b0, 8'd8);
        send_request(REQ_DRAW,  8'd57, 9'd5,   8'hA5, 1'b1, 8'h00);
        send_request(REQ_READ,  8'h00, 9'd0,   8'h00, 1'b0, 8'd47);
        send_request(REQ_READ,  8'h00, 9'd0,   8'h00, 1'b0, 8'd48);
        send_request(REQ_DRAW,  8'hFF, 9'd3,   8'hFF, 1'b1, 8'h00);
        send_request(REQ_DRAW,  8'd0,  9'd31,  8'h81, 1'b0, 8'h00);
        send_request(REQ_READ,  8'h00, 9'd0,   8'h00, 1'b0, 8'hFF);
        send_request(REQ_DRAW,  8'd0,  9'd32,  8'hFF, 1'b0, 8'h00);
        send_request(REQ_DRAW,  8'd0,  9'd256, 8'hFF, 1'b0, 8'h00);
        send_request(REQ_DRAW,  8'd0,  9'd511, 8'hFF, 1'b0, 8'h00);
        send_request(REQ_DRAW,  8'd57, 9'd5,   8'hA5, 1'b0, 8'h00);
        send_request(REQ_CLEAR, 8'hFF, 9'h1FF, 8'hFF, 1'b1, 8'hFF);
        send_request(REQ_NONE,  8'hFF, 9'h1FF, 8'hFF, 1'b1, 8'hFF);
        send_request(REQ_READ,  8'hFF, 9'h1FF, 8'hFF, 1'b1, 8'd47);
        send_request(REQ_READ,  8'hFF, 9'h1FF, 8'hFF, 1'b1, 8'hFF);
        send_request(REQ_DRAW,  8'd0,  9'd0,   8'h00, 1'b1, 8'h00);
        send_request(REQ_NONE,  8'h00, 9'd0,   8'h00, 1'b0, 8'h00);

        // random: mostly whole sprites, reads of the picture, some clears and noise
        while (n_sent < RANDOM_ITEMS + 23) begin
            send_no_gaps = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_sprite();
            end else if (pick < 90) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    send_request(REQ_READ, 8'($urandom), 9'($urandom), 8'($urandom),
                                 1'($urandom), 8'($urandom));
                end
            end else if (pick < 93) begin
                send_request(REQ_CLEAR, 8'($urandom), 9'($urandom), 8'($urandom),
                             1'($urandom), 8'($urandom));
            end else if (pick < 96) begin
                send_request(REQ_NONE, 8'($urandom), 9'($urandom), 8'($urandom),
                             1'($urandom), 8'($urandom));
            end else begin
                send_request(t_req_kind'($urandom_range(0, 3)), 8'($urandom),
                             9'($urandom), 8'($urandom), 1'($urandom), 8'($urandom));
            end
        end
        req_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d requests: %0d draw rows, %0d reads, %0d clears, %0d unused type",
                 n_sent, n_draw, n_read, n_clear, n_spare);
        $display("Responses compared: %0d, mismatches: %0d", checked, err_count);
        if (err_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
